[rtl/tsp_pkg.sv]
// Shared constants, codes, types and colour helper for the tile and sprite compositor.
`default_nettype none
package tsp_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 224;
  localparam int SPRITE_COUNT  = 48;

  localparam int SPR_IDX_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int SPR_CNT_W = $clog2(SPRITE_COUNT + 1);

  localparam int TILE_ROM_DEPTH  = 8192;
  localparam int SPR_ROM_WORDS   = 16384;
  localparam int PROM_DEPTH      = 544;
  localparam int MAP_DEPTH       = 1024;
  localparam int SPR_TABLE_BYTES = 4 * SPRITE_COUNT;

  localparam logic [9:0] SPRITE_LUT_BASE = 10'h020;
  localparam logic [9:0] CHAR_LUT_BASE   = 10'h120;
  localparam logic [9:0] SPR_Y_ORIGIN    = 10'd225;

  typedef enum logic [2:0] {
    REG_TILE_ROM  = 3'd0,
    REG_SPR_ROM   = 3'd1,
    REG_PROMS     = 3'd2,
    REG_CODES     = 3'd3,
    REG_ATTRS     = 3'd4,
    REG_SPR_TABLE = 3'd5
  } region_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MAP, ST_TROM, ST_CLUT, ST_CPEN,
    ST_SCAN, ST_SLUT, ST_SPEN, ST_PAL, ST_RGB
  } state_t;

  typedef struct packed {
    logic        tbl_we;
    logic        tbl_clr;
    logic        rom_we;
    logic [14:0] addr;
    logic [7:0]  data;
  } tsp_wr_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic [3:0] color;
    logic [3:0] pen;
  } tsp_res_t;

  function automatic logic [7:0] clamp8(input logic [9:0] v);
    clamp8 = (v > 10'd255) ? 8'hff : v[7:0];
  endfunction

  // resistor ladder weighting, packed 5-6-5
  function automatic logic [15:0] pal_rgb(input logic [7:0] d);
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    r = (d[0] ? 10'd74 : 10'd0) + (d[1] ? 10'd156 : 10'd0) + (d[2] ? 10'd255 : 10'd0);
    g = (d[3] ? 10'd74 : 10'd0) + (d[4] ? 10'd156 : 10'd0) + (d[5] ? 10'd255 : 10'd0);
    b = (d[6] ? 10'd96 : 10'd0) + (d[7] ? 10'd255 : 10'd0);
    r8 = clamp8(r);
    g8 = clamp8(g);
    b8 = clamp8(b);
    pal_rgb = {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

endpackage
`default_nettype wire

[rtl/tsp_if.sv]
// Valid/ready channel interfaces for input items, results and the flip register.
`default_nettype none
interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] region;
  logic [14:0] address;
  logic [7:0] data;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  modport source (output valid, kind, region, address, data, pixel_x, pixel_y, input ready);
  modport sink   (input valid, kind, region, address, data, pixel_x, pixel_y, output ready);
endinterface

interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  pen_index;
  logic [15:0] rgb565;
  modport source (output valid, pen_index, rgb565, input ready);
  modport sink   (input valid, pen_index, rgb565, output ready);
endinterface

interface tsp_cfg_if;
  logic valid;
  logic ready;
  logic flip_screen;
  modport source (output valid, flip_screen, input ready);
  modport sink   (input valid, flip_screen, output ready);
endinterface
`default_nettype wire

[rtl/tsp_sprite_scan.sv]
// Sprite table and sprite ROM with a pipelined first-hit scan over all sprites.
`default_nettype none
module tsp_sprite_scan (
  input  logic             clk,
  input  logic             rst,
  input  tsp_pkg::tsp_wr_t wr,
  input  logic             start,
  input  logic [7:0]       px,
  input  logic [7:0]       py,
  output tsp_pkg::tsp_res_t res
);
  import tsp_pkg::*;

  logic [31:0] tbl [SPRITE_COUNT];
  logic [15:0] rom [SPR_ROM_WORDS];

  logic                 busy;
  logic [SPR_CNT_W-1:0] rd_idx;
  logic                 issue;
  logic                 s1_v;
  logic [31:0]          tbl_q;
  logic                 s2_v;
  logic [3:0]           s2_color;
  logic [1:0]           s2_sh;
  logic [15:0]          rom_q;

  logic [7:0] b0, b1, b2, b3;
  logic signed [9:0] dx, dy;
  logic cov;
  logic [2:0] rx;
  logic [3:0] ry;
  logic [13:0] rom_addr;
  logic [3:0] v;
  logic hit;
  logic miss;

  assign issue = busy && (rd_idx < SPR_CNT_W'(SPRITE_COUNT));

  // table: byte writes, whole-word clear
  always_ff @(posedge clk) begin
    if (wr.tbl_clr) begin
      if (wr.addr < 15'(SPRITE_COUNT)) tbl[wr.addr[SPR_IDX_W-1:0]] <= '0;
    end else if (wr.tbl_we) begin
      case (wr.addr[1:0])
        2'd0:    tbl[wr.addr[SPR_IDX_W+1:2]][7:0]   <= wr.data;
        2'd1:    tbl[wr.addr[SPR_IDX_W+1:2]][15:8]  <= wr.data;
        2'd2:    tbl[wr.addr[SPR_IDX_W+1:2]][23:16] <= wr.data;
        default: tbl[wr.addr[SPR_IDX_W+1:2]][31:24] <= wr.data;
      endcase
    end
    if (issue) tbl_q <= tbl[rd_idx[SPR_IDX_W-1:0]];
  end

  // ROM word: low plane in [7:0], high plane in [15:8]
  always_ff @(posedge clk) begin
    if (wr.rom_we) begin
      if (wr.addr[14]) rom[wr.addr[13:0]][15:8] <= wr.data;
      else             rom[wr.addr[13:0]][7:0]  <= wr.data;
    end
    rom_q <= rom[rom_addr];
  end

  always_comb begin
    b0 = tbl_q[7:0];
    b1 = tbl_q[15:8];
    b2 = tbl_q[23:16];
    b3 = tbl_q[31:24];
    dx = $signed({2'b00, px}) - $signed({2'b00, b0});
    dy = $signed({2'b00, py}) + $signed({2'b00, b3}) - $signed(SPR_Y_ORIGIN);
    cov = (dx >= 0) && (dx <= 7) && (dy >= 0) && (dy <= 15);
    rx = dx[2:0] ^ {3{~b2[6]}};
    ry = dy[3:0] ^ {4{b2[7]}};
    rom_addr = {b2[5], b1[7:1], ry[3], b1[0], rx[2], ry[2:0]};
    v = {rom_q[{1'b1, s2_sh}], rom_q[{1'b0, s2_sh}],
         rom_q[{1'b1, s2_sh}], rom_q[{1'b0, s2_sh}]};
    v[3] = rom_q[8 + {1'b1, s2_sh}];
    v[2] = rom_q[8 + {1'b0, s2_sh}];
    v[1] = rom_q[{1'b1, s2_sh}];
    v[0] = rom_q[{1'b0, s2_sh}];
    hit  = s2_v && (v != 4'd0);
    miss = busy && !issue && !s1_v && !s2_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_idx   <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (hit || miss) begin
        res.hit   <= hit;
        res.color <= s2_color;
        res.pen   <= v;
      end
      if (start) begin
        busy   <= 1'b1;
        rd_idx <= '0;
        s1_v   <= 1'b0;
        s2_v   <= 1'b0;
      end else if (hit) begin
        busy     <= 1'b0;
        s1_v     <= 1'b0;
        s2_v     <= 1'b0;
        res.done <= 1'b1;
      end else if (miss) begin
        busy     <= 1'b0;
        res.done <= 1'b1;
      end else begin
        if (issue) rd_idx <= rd_idx + 1'b1;
        s1_v <= issue;
        s2_v <= s1_v && cov;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_color <= b2[3:0];
    s2_sh    <= ~rx[1:0];
  end

endmodule
`default_nettype wire

[rtl/tile_sprite_pixel_compositor.sv]
// Top level: memory loading, character layer lookup, sprite precedence and palette output.
`default_nettype none
// Memory-write transactions load the ROMs, colour PROMs, tile maps and sprite table; each
// is taken only while idle and gives no result. A pixel query runs a sequencer over the block
// RAMs: map read, tile ROM read, character lookup, then (unless a front cell's pen wins) a
// pipelined scan of the sprite table, one entry a cycle, then sprite lookup on a hit, and the
// palette read. An off-screen query goes straight to the palette read. A query ends early
// when a front cell wins; otherwise the sprite scan, which may run over the whole table, sets
// its length. One query is in flight at a time. After reset a clearing pass zeroes the tile
// maps and sprite table; no transaction is taken until it ends. The flip register is
// writable at any time.
module tile_sprite_pixel_compositor (
  input  logic      clk,
  input  logic      rst,
  tsp_in_if.sink    pix_in,
  tsp_out_if.source pix_out,
  tsp_cfg_if.sink   cfg
);
  import tsp_pkg::*;

  logic [7:0] tile_rom  [TILE_ROM_DEPTH];
  logic [7:0] proms     [PROM_DEPTH];
  logic [7:0] tile_codes[MAP_DEPTH];
  logic [7:0] tile_attrs[MAP_DEPTH];

  state_t state, state_next;
  logic       flip;
  logic [9:0] clr_idx;

  // query registers
  logic [7:0] qx, qy;
  logic [7:0] attr_r;
  logic [1:0] cv_r;
  logic [4:0] char_pen;
  logic [4:0] pen;
  logic [3:0] sp_color;
  logic [3:0] sp_v;

  // memory read side
  logic [9:0]  map_raddr;
  logic [12:0] trom_raddr;
  logic [9:0]  prom_raddr;
  logic [7:0]  code_q, attr_q, trom_q, prom_q;

  logic       accept, is_wr, is_query, offscreen;
  logic       front;
  logic       scan_start;
  logic [7:0] tcode_lo;
  logic       tfx, tfy;
  logic [2:0] trx, tryy;
  logic [1:0] tsh;
  logic [1:0] cv;
  logic [4:0] row, col;
  logic       out_free;

  tsp_wr_t  swr;
  tsp_res_t sres;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) flip <= 1'b0;
    else if (cfg.valid) flip <= cfg.flip_screen;
  end

  assign pix_in.ready = (state == ST_IDLE);
  assign accept   = pix_in.valid && pix_in.ready;
  assign is_wr    = accept && !pix_in.kind;
  assign is_query = accept && pix_in.kind;
  assign offscreen = ({1'b0, pix_in.pixel_x} >= 9'(SCREEN_WIDTH)) ||
                     ({1'b0, pix_in.pixel_y} >= 9'(SCREEN_HEIGHT));
  assign out_free = !pix_out.valid || pix_out.ready;
  assign front    = !attr_r[4];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == 10'(MAP_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (is_query) state_next = offscreen ? ST_PAL : ST_MAP;
      ST_MAP:   state_next = ST_TROM;
      ST_TROM:  state_next = ST_CLUT;
      ST_CLUT:  state_next = ST_CPEN;
      ST_CPEN:  state_next = (front && cv_r != 2'd0) ? ST_PAL : ST_SCAN;
      ST_SCAN:  if (sres.done) state_next = sres.hit ? ST_SLUT : ST_PAL;
      ST_SLUT:  state_next = ST_SPEN;
      ST_SPEN:  state_next = ST_PAL;
      ST_PAL:   state_next = ST_RGB;
      ST_RGB:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // character cell and glyph addressing
  always_comb begin
    if (flip) begin
      col = ~qx[7:3];
      row = 5'd28 - qy[7:3];
    end else begin
      col = qx[7:3];
      row = 5'(({1'b0, qy} + 9'd16) >> 3);
    end
    tfx  = attr_q[6] ^ flip;
    tfy  = attr_q[7] ^ flip;
    trx  = qx[2:0] ^ {3{tfx}};
    tryy = qy[2:0] ^ {3{tfy}};
    tcode_lo = code_q;
    tsh  = ~trx[1:0];
    cv   = {trom_q[{1'b1, tsh}], trom_q[{1'b0, tsh}]};
  end

  // read addresses and sprite scan control
  always_comb begin
    map_raddr  = {row, col};
    trom_raddr = {attr_q[5], tcode_lo, trx[2], tryy};
    prom_raddr = {5'd0, pen};
    scan_start = 1'b0;
    case (state)
      ST_CLUT:  prom_raddr = CHAR_LUT_BASE + {2'b00, attr_r[3:0], 2'b00, cv};
      ST_CPEN:  scan_start = !(front && cv_r != 2'd0);
      ST_SLUT:  prom_raddr = SPRITE_LUT_BASE + {2'b00, sp_color, sp_v};
      default:  prom_raddr = {5'd0, pen};
    endcase
    swr.tbl_clr = (state == ST_CLEAR);
    swr.tbl_we  = is_wr && (pix_in.region == REG_SPR_TABLE) &&
                  (pix_in.address < 15'(SPR_TABLE_BYTES));
    swr.rom_we  = is_wr && (pix_in.region == REG_SPR_ROM);
    swr.addr    = (state == ST_CLEAR) ? {5'd0, clr_idx} : pix_in.address;
    swr.data    = pix_in.data;
  end

  // block RAMs
  always_ff @(posedge clk) begin
    if (is_wr && pix_in.region == REG_TILE_ROM && pix_in.address[14:13] == 2'b00)
      tile_rom[pix_in.address[12:0]] <= pix_in.data;
    trom_q <= tile_rom[trom_raddr];
  end

  always_ff @(posedge clk) begin
    if (is_wr && pix_in.region == REG_PROMS && pix_in.address < 15'(PROM_DEPTH))
      proms[pix_in.address[9:0]] <= pix_in.data;
    prom_q <= proms[prom_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      tile_codes[clr_idx] <= 8'd0;
      tile_attrs[clr_idx] <= 8'd0;
    end else if (is_wr && pix_in.address < 15'(MAP_DEPTH)) begin
      if (pix_in.region == REG_CODES) tile_codes[pix_in.address[9:0]] <= pix_in.data;
      if (pix_in.region == REG_ATTRS) tile_attrs[pix_in.address[9:0]] <= pix_in.data;
    end
    code_q <= tile_codes[map_raddr];
    attr_q <= tile_attrs[map_raddr];
  end

  tsp_sprite_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .wr    (swr),
    .start (scan_start),
    .px    (qx),
    .py    (qy),
    .res   (sres)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      pix_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == ST_RGB && out_free) pix_out.valid <= 1'b1;
      else if (pix_out.ready)          pix_out.valid <= 1'b0;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (is_query) begin
      qx  <= pix_in.pixel_x;
      qy  <= pix_in.pixel_y;
      pen <= 5'd0;
    end
    case (state)
      ST_TROM: attr_r <= attr_q;
      ST_CLUT: cv_r <= cv;
      ST_CPEN: begin
        char_pen <= {1'b1, prom_q[3:0]};
        if (front && cv_r != 2'd0) pen <= {1'b1, prom_q[3:0]};
      end
      ST_SCAN: begin
        sp_color <= sres.color;
        sp_v     <= sres.pen;
        // no sprite: a behind cell shows, pen 0 included
        if (sres.done && !sres.hit) pen <= front ? 5'd0 : char_pen;
      end
      ST_SPEN: pen <= {1'b0, prom_q[3:0]};
      ST_RGB: if (out_free) begin
        pix_out.pen_index <= pen;
        pix_out.rgb565    <= pal_rgb(prom_q);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !pix_in.ready)
    else $error("input taken during clearing pass");
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    sres.done |-> state == ST_SCAN)
    else $error("sprite scan finished outside scan state");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RGB && !pix_out.valid) |=> pix_out.valid)
    else $error("finished query not presented");
`endif

endmodule
`default_nettype wire
